[design/rlm_pkg.sv]
package rlm_pkg;

   // Sample and accumulator widths
   localparam int SAMPLE_W = 32;
   localparam int PROD_W   = 2 * SAMPLE_W;
   localparam int SCALE_SH = 16;
   localparam int SUM_W    = 57;

   // Mean fits in 48 bits (at most 2^46), its root in 24 bits
   localparam int MEAN_W   = 48;
   localparam int ROOT_W   = MEAN_W / 2;
   localparam int SUB_W    = ROOT_W + 2;
   localparam int ITER_W   = 6;

   // Result formats
   localparam int RMS_W    = 16;
   localparam int BAR_W    = 6;
   localparam int RATIO_SH = 7;
   localparam logic [BAR_W-1:0] BAR_FULL = 6'd50;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic [RMS_W-1:0] rms_level;
      logic [BAR_W-1:0] bar_level;
      logic             overflow;
   } rsp_type;

   // Sequencer strobes to the accumulator
   typedef struct packed {
      logic take;
      logic mul;
      logic add;
      logic clear;
   } acc_ctl_type;

endpackage

[design/rlm_accum.sv]
module rlm_accum #(
   parameter int MAX_SAMPLES = 1024,
   parameter int CNT_W       = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rlm_pkg::acc_ctl_type               ctl,
   input  logic signed [rlm_pkg::SAMPLE_W-1:0] sample,
   output logic [rlm_pkg::SUM_W-1:0]          sum,
   output logic [CNT_W-1:0]                   count,
   output logic                               overflow_seen
);

   logic [rlm_pkg::SAMPLE_W-1:0] raw;
   logic [rlm_pkg::SAMPLE_W-1:0] mag_in;
   logic [rlm_pkg::SAMPLE_W-1:0] mag_ff;
   logic                         skip_in;
   logic                         skip_ff;
   logic [rlm_pkg::PROD_W-1:0]   prod_in;
   logic [rlm_pkg::PROD_W-1:0]   prod_ff;
   logic [rlm_pkg::SUM_W-1:0]    sum_in;
   logic [rlm_pkg::SUM_W-1:0]    sum_ff;
   logic [CNT_W-1:0]             count_in;
   logic [CNT_W-1:0]             count_ff;
   logic                         ovf_in;
   logic                         ovf_ff;

   // Take magnitude; drop the sample once the block is full
   assign raw     = sample;
   assign mag_in  = raw[rlm_pkg::SAMPLE_W-1] ? (~raw + 1'b1) : raw;
   assign skip_in = (count_ff == CNT_W'(MAX_SAMPLES));

   // Square the magnitude
   assign prod_in = mag_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (ctl.take) begin
         mag_ff  <= mag_in;
         skip_ff <= skip_in;
      end
      if (ctl.mul) begin
         prod_ff <= prod_in;
      end
   end

   // Accumulate the scaled square and count the sample
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (ctl.clear) begin
         sum_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (ctl.take && skip_in) begin
            ovf_in = 1'b1;
         end
         if (ctl.add && !skip_ff) begin
            sum_in   = sum_ff + rlm_pkg::SUM_W'(prod_ff[rlm_pkg::PROD_W-1:rlm_pkg::SCALE_SH]);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign sum           = sum_ff;
   assign count         = count_ff;
   assign overflow_seen = ovf_ff;

endmodule

[design/rlm_divsqrt.sv]
module rlm_divsqrt #(
   parameter int CNT_W = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [rlm_pkg::SUM_W-1:0]    dividend,
   input  logic [CNT_W-1:0]             divisor,
   output logic                         busy,
   output logic [rlm_pkg::ROOT_W-1:0]   root
);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_DIV  = 3'b010,
      U_SQRT = 3'b100
   } unit_state_type;

   unit_state_type               state_ff;
   unit_state_type               state_in;
   logic [rlm_pkg::SUM_W-1:0]    work_ff;
   logic [rlm_pkg::SUM_W-1:0]    work_in;
   logic [CNT_W-1:0]             div_ff;
   logic [CNT_W-1:0]             div_in;
   logic [rlm_pkg::SUB_W-1:0]    rem_ff;
   logic [rlm_pkg::SUB_W-1:0]    rem_in;
   logic [rlm_pkg::ROOT_W-1:0]   root_ff;
   logic [rlm_pkg::ROOT_W-1:0]   root_in;
   logic [rlm_pkg::ITER_W-1:0]   iter_ff;
   logic [rlm_pkg::ITER_W-1:0]   iter_in;

   // Shared trial subtractor
   logic [rlm_pkg::SUB_W-1:0]    sub_a;
   logic [rlm_pkg::SUB_W-1:0]    sub_b;
   logic [rlm_pkg::SUB_W:0]      diff;
   logic                         ge;

   assign diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign ge   = ~diff[rlm_pkg::SUB_W];

   // Feed the subtractor: one quotient bit or one root bit per cycle
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      unique case (state_ff)
         U_DIV: begin
            sub_a = {rem_ff[rlm_pkg::SUB_W-2:0], work_ff[rlm_pkg::SUM_W-1]};
            sub_b = rlm_pkg::SUB_W'(div_ff);
         end
         U_SQRT: begin
            sub_a = {rem_ff[rlm_pkg::SUB_W-3:0], work_ff[rlm_pkg::MEAN_W-1 -: 2]};
            sub_b = {root_ff, 2'b01};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
   end

   // Sequence: restoring divide, then digit-by-digit square root
   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      iter_in  = iter_ff;
      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               // Zero count reads as a zero mean
               work_in  = (divisor == '0) ? '0 : dividend;
               div_in   = (divisor == '0) ? CNT_W'(1) : divisor;
               rem_in   = '0;
               root_in  = '0;
               iter_in  = rlm_pkg::ITER_W'(rlm_pkg::SUM_W - 1);
               state_in = U_DIV;
            end
         end
         U_DIV: begin
            rem_in  = ge ? diff[rlm_pkg::SUB_W-1:0] : sub_a;
            work_in = {work_ff[rlm_pkg::SUM_W-2:0], ge};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               rem_in   = '0;
               iter_in  = rlm_pkg::ITER_W'(rlm_pkg::ROOT_W - 1);
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            rem_in  = ge ? diff[rlm_pkg::SUB_W-1:0] : sub_a;
            root_in = {root_ff[rlm_pkg::ROOT_W-2:0], ge};
            work_in = {work_ff[rlm_pkg::SUM_W-3:0], 2'b00};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      iter_ff <= iter_in;
   end

   assign busy = (state_ff != U_IDLE);
   assign root = root_ff;

endmodule

[design/block_rms_level_meter.sv]
// Block RMS level meter.
// Input channel req_valid/req_ready/req_data carries one signed 32-bit audio
// sample per item plus a last flag that closes the block. Result channel
// rsp_valid/rsp_ready/rsp_data carries one item per block: RMS in unsigned
// Q0.16 (saturated to 65535), a 0..50 bar level and an overflow flag that
// marks a block longer than MAX_SAMPLES (extra samples are not summed).
// An ordinary sample is accepted, squared in the 32x32 multiplier and added
// into the 57-bit sum. req_ready is low from each accept until the add (for a
// last sample, until the result is loaded), so no new sample enters meanwhile.
// A sample with last set then hands the sum and count to the shared
// shift-subtract unit, which runs the restoring divide (one quotient bit a
// cycle) and then the square root (one root bit a cycle); the sequencer sees
// the unit go idle and scales the root into the result register.
// The result appears on rsp_valid the cycle after that, and the next sample
// may enter then.
// A finished result waits in the output register while the next block is
// accumulated; only a following last sample waits for it to be taken.
// Reset (synchronous, active high) clears the sum, count, overflow flag,
// both sequencers and the result valid.
module block_rms_level_meter #(
   parameter int MAX_SAMPLES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rlm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rlm_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int R_W   = rlm_pkg::ROOT_W - rlm_pkg::RATIO_SH;
   localparam int BP_W  = R_W + rlm_pkg::BAR_W;
   localparam int BR_W  = BP_W - rlm_pkg::RMS_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MUL   = 6'b000010,
      S_ACC   = 6'b000100,
      S_START = 6'b001000,
      S_WAIT  = 6'b010000,
      S_BAR   = 6'b100000
   } state_type;

   state_type                    state_ff;
   state_type                    state_in;
   logic                         last_ff;
   logic                         last_in;
   logic                         ovf_hold_ff;
   logic                         ovf_hold_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   rlm_pkg::rsp_type             rsp_ff;
   rlm_pkg::rsp_type             rsp_in;
   logic                         load_rsp;
   logic                         unit_start;
   rlm_pkg::acc_ctl_type         acc_ctl;
   logic [rlm_pkg::SUM_W-1:0]    acc_sum;
   logic [CNT_W-1:0]             acc_count;
   logic                         acc_ovf;
   logic                         unit_busy;
   logic [rlm_pkg::ROOT_W-1:0]   unit_root;
   logic [R_W-1:0]               r_val;
   logic [BP_W-1:0]              bar_prod;
   logic [BR_W-1:0]              bar_raw;

   rlm_accum #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .CNT_W       (CNT_W)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .ctl           (acc_ctl),
      .sample        (req_data.sample),
      .sum           (acc_sum),
      .count         (acc_count),
      .overflow_seen (acc_ovf)
   );

   rlm_divsqrt #(
      .CNT_W (CNT_W)
   ) u_divsqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .dividend (acc_sum),
      .divisor  (acc_count),
      .busy     (unit_busy),
      .root     (unit_root)
   );

   assign req_ready = (state_ff == S_IDLE);

   // Sequence one item through square, add and, on last, divide and root
   always_comb begin
      state_in    = state_ff;
      last_in     = last_ff;
      ovf_hold_in = ovf_hold_ff;
      acc_ctl     = '0;
      unit_start  = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               acc_ctl.take = 1'b1;
               last_in      = req_data.last;
               state_in     = S_MUL;
            end
         end
         S_MUL: begin
            acc_ctl.mul = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            acc_ctl.add = 1'b1;
            state_in    = last_ff ? S_START : S_IDLE;
         end
         S_START: begin
            unit_start    = 1'b1;
            acc_ctl.clear = 1'b1;
            ovf_hold_in   = acc_ovf;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (!unit_busy) begin
               state_in = S_BAR;
            end
         end
         S_BAR: begin
            // Hold until the previous result has been taken
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Scale the root into the result formats
   assign r_val    = unit_root[rlm_pkg::ROOT_W-1:rlm_pkg::RATIO_SH];
   assign bar_prod = BP_W'(r_val) * BP_W'(rlm_pkg::BAR_FULL);
   assign bar_raw  = bar_prod[BP_W-1:rlm_pkg::RMS_W];

   always_comb begin
      rsp_in.rms_level = r_val[R_W-1] ? '1 : r_val[rlm_pkg::RMS_W-1:0];
      if (bar_raw > BR_W'(rlm_pkg::BAR_FULL)) begin
         rsp_in.bar_level = rlm_pkg::BAR_FULL;
      end else begin
         rsp_in.bar_level = bar_raw[rlm_pkg::BAR_W-1:0];
      end
      rsp_in.overflow = ovf_hold_ff;
   end

   // Output register valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ovf_hold_ff  <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ovf_hold_ff  <= ovf_hold_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/rlm_checker.sv]
module rlm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rlm_pkg::rsp_type rsp_data
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed or dropped");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Bar level never exceeds full scale
   a_bar_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bar_level <= rlm_pkg::BAR_FULL)
      else $error("bar level above full scale");

   // A full bar implies a saturated RMS
   a_bar_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bar_level == rlm_pkg::BAR_FULL |-> rsp_data.rms_level == '1)
      else $error("full bar without saturated level");

   // The sequencer never accepts items back to back
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted in back-to-back cycles");

endmodule

bind block_rms_level_meter rlm_checker u_rlm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[test/tb_block_rms_level_meter.sv]
module tb_block_rms_level_meter;

   localparam int BLOCK_LIMIT    = 1024;
   localparam int RANDOM_ITEMS   = 340;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {
      SIG_NOISE,
      SIG_SCALED,
      SIG_SQUARE,
      SIG_EXTREME
   } signal_kind_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rlm_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rlm_pkg::rsp_type rsp_data;

   // Expected block levels, oldest first
   rlm_pkg::rsp_type expected_levels[$];

   // Running block state of the predictor
   logic [rlm_pkg::SUM_W-1:0] block_sum;
   logic [10:0]               block_count;
   logic                      block_overflow;

   int error_count;
   int stall_cycles;
   bit steady;

   block_rms_level_meter #(
      .MAX_SAMPLES(BLOCK_LIMIT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Integer square root, one root bit per pass from the top
   function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] trial;
      int          b;
      root = '0;
      for (b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) root = trial;
      end
      return root;
   endfunction

   // Accumulate one sample; on the closing sample push the block level
   function automatic void track_sample(input rlm_pkg::req_type item);
      logic [31:0]      magnitude;
      logic [63:0]      square;
      logic [63:0]      mean;
      logic [63:0]      level;
      logic [63:0]      bar;
      rlm_pkg::rsp_type result;
      magnitude = item.sample;
      if (magnitude[31]) magnitude = ~magnitude + 32'd1;
      square = ({32'd0, magnitude} * {32'd0, magnitude}) >> rlm_pkg::SCALE_SH;
      if (block_count < BLOCK_LIMIT) begin
         block_sum   = block_sum + square[rlm_pkg::SUM_W-1:0];
         block_count = block_count + 11'd1;
      end else begin
         block_overflow = 1'b1;
      end
      if (item.last) begin
         if (block_count == 0) mean = '0;
         else mean = {{(64-rlm_pkg::SUM_W){1'b0}}, block_sum} / {53'd0, block_count};
         level = floor_sqrt(mean) >> rlm_pkg::RATIO_SH;
         bar = (level * {58'd0, rlm_pkg::BAR_FULL}) >> rlm_pkg::SCALE_SH;
         if (bar > {58'd0, rlm_pkg::BAR_FULL}) bar = {58'd0, rlm_pkg::BAR_FULL};
         result.rms_level = (level > 64'd65535) ? 16'hFFFF : level[rlm_pkg::RMS_W-1:0];
         result.bar_level = bar[rlm_pkg::BAR_W-1:0];
         result.overflow  = block_overflow;
         expected_levels.push_back(result);
         block_sum      = '0;
         block_count    = '0;
         block_overflow = 1'b0;
      end
   endfunction

   // Compare one result item against the oldest expected level
   function automatic void check_level(input rlm_pkg::rsp_type actual);
      rlm_pkg::rsp_type wanted;
      if (expected_levels.size() == 0) begin
         $display("%0t: unexpected result rms_level %0d bar_level %0d overflow %0d",
                  $time, actual.rms_level, actual.bar_level, actual.overflow);
         error_count++;
         return;
      end
      wanted = expected_levels.pop_front();
      if (actual.rms_level !== wanted.rms_level) begin
         $display("%0t: rms_level expected %0d actual %0d",
                  $time, wanted.rms_level, actual.rms_level);
         error_count++;
      end
      if (actual.bar_level !== wanted.bar_level) begin
         $display("%0t: bar_level expected %0d actual %0d",
                  $time, wanted.bar_level, actual.bar_level);
         error_count++;
      end
      if (actual.overflow !== wanted.overflow) begin
         $display("%0t: overflow expected %0d actual %0d",
                  $time, wanted.overflow, actual.overflow);
         error_count++;
      end
   endfunction

   // Check results before predicting, so an early result is caught
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_level(rsp_data);
         if (req_valid && req_ready) track_sample(req_data);
      end
   end

   // Mostly short gaps, a few long ones, none in steady stretches
   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 50);
   endfunction

   // Stall the result side at random
   initial begin
      int hold;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         hold = pick_gap();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // End the run when no item moves on either side for too long
   initial begin
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
      end
      $display("%0t: watchdog expired, no item moved for %0d cycles",
               $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Offer one sample and hold it until accepted
   task automatic send_sample(input logic signed [31:0] value, input logic close_block);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{sample: value, last: close_block};
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold off the sender until every expected level has arrived
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] draw_sample(input signal_kind_type kind,
                                                      input int shift,
                                                      input logic [31:0] amplitude);
      logic signed [31:0] value;
      case (kind)
         SIG_NOISE: begin
            value = $urandom;
         end
         SIG_SCALED: begin
            value = $urandom;
            value = value >>> shift;
         end
         SIG_SQUARE: begin
            value = $urandom_range(0, 1) ? amplitude : -amplitude;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: value = 32'sh8000_0000;
               1: value = 32'sh7FFF_FFFF;
               2: value = 32'sd0;
               3: value = -32'sd1;
               default: value = 32'sd1;
            endcase
         end
      endcase
      // Sprinkle full-scale values into any signal
      if ($urandom_range(0, 29) == 0) value = 32'sh8000_0000;
      return value;
   endfunction

   // Extremes, rounding of small squares, truncating divide, bit patterns
   task automatic test_directed_levels();
      send_sample(32'sd0, 1'b1);
      send_sample(32'sh8000_0000, 1'b1);
      send_sample(32'sh7FFF_FFFF, 1'b1);
      send_sample(-32'sd1, 1'b1);
      send_sample(32'sd1, 1'b1);
      send_sample(32'sh0000_0100, 1'b1);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b1);
      send_sample(32'sd1000, 1'b0);
      send_sample(-32'sd70000, 1'b0);
      send_sample(32'sd123456789, 1'b1);
      send_sample(32'sh4000_0000, 1'b0);
      send_sample(-32'sh4000_0000, 1'b0);
      send_sample(32'sh4000_0000, 1'b0);
      send_sample(-32'sh4000_0000, 1'b1);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sd0, 1'b1);
      send_sample(32'sh5555_5555, 1'b0);
      send_sample(32'shAAAA_AAAA, 1'b1);
   endtask

   // Fill a block to the limit, then past it; ignored samples are full scale
   task automatic test_block_length_limit();
      int i;
      steady = 1'b1;
      for (i = 0; i < BLOCK_LIMIT + 6; i++) begin
         if (i < BLOCK_LIMIT) send_sample(draw_sample(SIG_NOISE, 0, '0), 1'b0);
         else send_sample(32'sh8000_0000, i == BLOCK_LIMIT + 5);
      end
      steady = 1'b0;
      // A short block right after must come out clean
      send_sample(32'sh0001_0000, 1'b0);
      send_sample(-32'sh0001_0000, 1'b1);
   endtask

   // Random blocks, mostly short, with varied amplitude and signal shape
   task automatic test_random_blocks();
      int              sent;
      int              length;
      int              roll;
      int              shift;
      int              i;
      signal_kind_type kind;
      logic [31:0]     amplitude;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) steady = ~steady;
         if ($urandom_range(0, 24) == 0) pause_until_drained();
         roll = $urandom_range(0, 99);
         if (roll < 70) length = $urandom_range(1, 8);
         else if (roll < 95) length = $urandom_range(9, 64);
         else length = $urandom_range(65, 300);
         kind      = signal_kind_type'($urandom_range(0, 3));
         shift     = $urandom_range(0, 31);
         amplitude = $urandom >> $urandom_range(0, 31);
         for (i = 0; i < length; i++)
            send_sample(draw_sample(kind, shift, amplitude), i == length - 1);
         sent += length;
      end
      steady = 1'b0;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      steady         = 1'b0;
      error_count    = 0;
      block_sum      = '0;
      block_count    = '0;
      block_overflow = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_levels();
      pause_until_drained();
      test_block_length_limit();
      pause_until_drained();
      test_random_blocks();
      pause_until_drained();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
design/rlm_pkg.sv
design/rlm_accum.sv
design/rlm_divsqrt.sv
design/block_rms_level_meter.sv
design/rlm_checker.sv
test/tb_block_rms_level_meter.sv
